FILE: hdl/msc_pkg.sv
package msc_pkg;

   localparam int LINE_WIDTH         = 128;
   localparam int SMALL_SPRITE_COUNT = 32;
   localparam int BIG_SPRITE_COUNT   = 32;

   localparam int SMALL_BYTES = SMALL_SPRITE_COUNT * 16;
   localparam int BIG_BYTES   = BIG_SPRITE_COUNT * 64;

   localparam int LINE_AW  = $clog2(LINE_WIDTH);
   localparam int SMALL_AW = $clog2(SMALL_BYTES);
   localparam int BIG_AW   = $clog2(BIG_BYTES);

   typedef enum logic [2:0] {
      OP_WR_SMALL = 3'd0,
      OP_WR_BIG   = 3'd1,
      OP_WR_LINE  = 3'd2,
      OP_DRAW     = 3'd3,
      OP_RD_LINE  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_COL_MASK,
      ST_COL_PAT,
      ST_COL_BLEND,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic dispatch;
      logic rd_mask;
      logic rd_pat;
      logic blend;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic draw_go;
      logic last_col;
      logic rsp_free;
   } status_type;

endpackage

FILE: hdl/msc_ctrl.sv
module msc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  msc_pkg::status_type status,
   output msc_pkg::cmd_type    cmd
);
   import msc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.dispatch = 1'b1;
            state_in     = status.draw_go ? ST_COL_MASK : ST_RESP;
         end
         ST_COL_MASK: begin
            cmd.rd_mask = 1'b1;
            state_in    = ST_COL_PAT;
         end
         ST_COL_PAT: begin
            cmd.rd_pat = 1'b1;
            state_in   = ST_COL_BLEND;
         end
         ST_COL_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = status.last_col ? ST_RESP : ST_COL_MASK;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/msc_dpath.sv
module msc_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_operation,
   input  logic [10:0]         req_address,
   input  logic [7:0]          req_data,
   input  logic [7:0]          req_sprite_x,
   input  logic [7:0]          req_sprite_y,
   input  logic                req_sprite_big,
   input  logic [4:0]          req_sprite_index,
   input  logic [2:0]          req_row_page,
   input  logic                req_last_sprite,
   input  msc_pkg::cmd_type    cmd,
   output msc_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_drawn,
   output logic                rsp_list_done
);
   import msc_pkg::*;

   typedef enum logic [1:0] {
      BM_ALIGNED,
      BM_UP,
      BM_DOWN,
      BM_MID
   } blend_mode_type;

   logic [2:0]  op_ff;
   logic [10:0] addr_ff;
   logic [7:0]  data_ff;
   logic [7:0]  sx_ff;
   logic [7:0]  sy_ff;
   logic        big_ff;
   logic [4:0]  idx_ff;
   logic [2:0]  page_ff;
   logic        last_ff;
   logic [4:0]  col_ff;

   logic [7:0] small_mem [SMALL_BYTES];
   logic [7:0] big_mem [BIG_BYTES];
   logic [7:0] line_mem [LINE_WIDTH];
   logic [LINE_WIDTH-1:0] line_vld_ff;

   logic [7:0] small_rd_ff;
   logic [7:0] big_rd_a_ff;
   logic [7:0] big_rd_b_ff;
   logic [7:0] line_rd_ff;
   logic       line_rd_vld_ff;
   logic [7:0] mask_ff;
   logic [7:0] mask2_ff;

   logic       rsp_valid_ff;
   logic [7:0] read_data_ff;
   logic       drawn_ff;
   logic       done_ff;

   logic [8:0]  sx9, sy9, top9, size9, room9, col9;
   logic [4:0]  width5;
   logic        is_draw, off_page, idx_ok, visible, adj_half, line_addr_ok;
   logic [2:0]  offs;
   logic [3:0]  shr;
   blend_mode_type mode;
   logic [13:0] addr14, col14, small_base, big_base;
   logic [13:0] small_addr14, big_addr_a14, big_addr_b14;
   logic        small_we, big_we, line_we, line_re, pat_re;
   logic [LINE_AW-1:0] line_wa, line_ra;
   logic [7:0]  line_wd, line_cur, pat, pat2, m, p, blend_byte;
   logic        rsp_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         addr_ff <= req_address;
         data_ff <= req_data;
         sx_ff   <= req_sprite_x;
         sy_ff   <= req_sprite_y;
         big_ff  <= req_sprite_big;
         idx_ff  <= req_sprite_index;
         page_ff <= req_row_page;
         last_ff <= req_last_sprite;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (cmd.capture) begin
         col_ff <= '0;
      end else if (cmd.blend) begin
         col_ff <= col_ff + 5'd1;
      end
   end

   assign sx9   = {1'b0, sx_ff};
   assign sy9   = {1'b0, sy_ff};
   assign top9  = {3'b000, page_ff, 3'b000};
   assign size9 = big_ff ? 9'd16 : 9'd8;
   assign room9 = 9'(LINE_WIDTH) - sx9;
   assign col9  = sx9 + {4'b0000, col_ff};

   assign is_draw  = (op_ff == OP_DRAW);
   assign off_page = (sy9 >= top9 + 9'd8) || (sy9 + size9 <= top9)
                     || (sx9 >= 9'(LINE_WIDTH));
   assign idx_ok   = big_ff ? (32'(idx_ff) < BIG_SPRITE_COUNT)
                            : (32'(idx_ff) < SMALL_SPRITE_COUNT);
   assign visible  = is_draw && !off_page && idx_ok;
   assign width5   = (room9 < size9) ? room9[4:0] : size9[4:0];
   assign adj_half = (sy9 + 9'd8 <= top9);

   assign offs = sy_ff[2:0];
   assign shr  = 4'd8 - {1'b0, offs};

   always_comb begin
      if (offs == 3'd0) begin
         mode = BM_ALIGNED;
      end else if (big_ff) begin
         if (sy9 + 9'd8 < top9) begin
            mode = BM_UP;
         end else if (sy9 > top9) begin
            mode = BM_DOWN;
         end else begin
            mode = BM_MID;
         end
      end else begin
         mode = (sy9 > top9) ? BM_DOWN : BM_UP;
      end
   end

   assign addr14       = {3'b000, addr_ff};
   assign col14        = {9'd0, col_ff};
   assign small_base   = {5'd0, idx_ff, 4'b0000};
   assign big_base     = {3'b000, idx_ff, 6'b000000} + (adj_half ? 14'd16 : 14'd0);
   assign small_addr14 = small_base + col14 + (cmd.rd_pat ? 14'd8 : 14'd0);
   assign big_addr_a14 = big_base + col14 + (cmd.rd_pat ? 14'd32 : 14'd0);
   assign big_addr_b14 = big_addr_a14 + 14'd16;
   assign pat_re       = cmd.rd_mask | cmd.rd_pat;

   assign small_we = cmd.dispatch && (op_ff == OP_WR_SMALL) && (32'(addr_ff) < SMALL_BYTES);
   assign big_we   = cmd.dispatch && (op_ff == OP_WR_BIG) && (32'(addr_ff) < BIG_BYTES);

   always_ff @(posedge clock) begin
      if (small_we) begin
         small_mem[addr14[SMALL_AW-1:0]] <= data_ff;
      end
      if (pat_re) begin
         small_rd_ff <= small_mem[small_addr14[SMALL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (big_we) begin
         big_mem[addr14[BIG_AW-1:0]] <= data_ff;
      end
      if (pat_re) begin
         big_rd_a_ff <= big_mem[big_addr_a14[BIG_AW-1:0]];
         big_rd_b_ff <= big_mem[big_addr_b14[BIG_AW-1:0]];
      end
   end

   assign line_addr_ok = (32'(addr_ff) < LINE_WIDTH);
   assign line_we = cmd.blend || (cmd.dispatch && (op_ff == OP_WR_LINE) && line_addr_ok);
   assign line_wa = cmd.blend ? col9[LINE_AW-1:0] : addr14[LINE_AW-1:0];
   assign line_wd = cmd.blend ? blend_byte : data_ff;
   assign line_re = cmd.rd_mask || (cmd.dispatch && (op_ff == OP_RD_LINE));
   assign line_ra = cmd.rd_mask ? col9[LINE_AW-1:0] : addr14[LINE_AW-1:0];

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_wa] <= line_wd;
      end
      if (line_re) begin
         line_rd_ff     <= line_mem[line_ra];
         line_rd_vld_ff <= line_vld_ff[line_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_vld_ff <= '0;
      end else if (line_we) begin
         line_vld_ff[line_wa] <= 1'b1;
      end
   end

   assign line_cur = line_rd_vld_ff ? line_rd_ff : 8'h00;

   always_ff @(posedge clock) begin
      if (cmd.rd_pat) begin
         mask_ff  <= big_ff ? big_rd_a_ff : small_rd_ff;
         mask2_ff <= big_rd_b_ff;
      end
   end

   assign pat  = big_ff ? big_rd_a_ff : small_rd_ff;
   assign pat2 = big_rd_b_ff;

   always_comb begin
      case (mode)
         BM_UP: begin
            m = (mask_ff >> shr) | 8'(8'hff << offs);
            p = pat >> shr;
         end
         BM_DOWN: begin
            m = 8'(mask_ff << offs) | (8'hff >> shr);
            p = 8'(pat << offs);
         end
         BM_MID: begin
            m = (mask_ff >> shr) | 8'(mask2_ff << offs);
            p = (pat >> shr) | 8'(pat2 << offs);
         end
         default: begin
            m = mask_ff;
            p = pat;
         end
      endcase
   end

   assign blend_byte = (line_cur & m) | p;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         read_data_ff <= ((op_ff == OP_RD_LINE) && line_addr_ok) ? line_cur : 8'h00;
         drawn_ff     <= visible;
         done_ff      <= is_draw && last_ff;
      end
   end

   assign status.draw_go  = visible;
   assign status.last_col = (col_ff == width5 - 5'd1);
   assign status.rsp_free = rsp_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_drawn     = drawn_ff;
   assign rsp_list_done = done_ff;

   a_blend_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.blend |-> visible && (col_ff < width5))
      else $error("blend outside the sprite width");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("result loaded over a held beat");

   a_pat_after_mask: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_pat |-> $past(cmd.rd_mask))
      else $error("pattern fetch without mask fetch");

   a_blend_marks_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.blend |=> line_vld_ff[$past(line_wa)])
      else $error("blended column not marked written");

endmodule

FILE: hdl/masked_sprite_page_compositor.sv
// Flow: an accepted beat is captured and dispatched, then its result is loaded into the
// result beat; a visible draw of W columns (W up to 16) first runs the column steps.
// Throughput: one item at a time; each column takes a mask fetch, a pattern fetch and a
// line read-modify-write of the line buffer. Next item is taken once the result loads.
// Reset: synchronous, active high; clears the controller, the result beat and the line
// buffer written flags, so the line reads as zero. Pattern stores are not cleared.
module masked_sprite_page_compositor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [10:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [7:0]  req_sprite_x,
   input  logic [7:0]  req_sprite_y,
   input  logic        req_sprite_big,
   input  logic [4:0]  req_sprite_index,
   input  logic [2:0]  req_row_page,
   input  logic        req_last_sprite,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_drawn,
   output logic        rsp_list_done
);
   import msc_pkg::*;

   cmd_type    cmd;
   status_type status;

   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_data         (req_data),
      .req_sprite_x     (req_sprite_x),
      .req_sprite_y     (req_sprite_y),
      .req_sprite_big   (req_sprite_big),
      .req_sprite_index (req_sprite_index),
      .req_row_page     (req_row_page),
      .req_last_sprite  (req_last_sprite),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_drawn        (rsp_drawn),
      .rsp_list_done    (rsp_list_done)
   );

endmodule
